FILE: sv/msb_first_bit_packer_defines.svh
// ----------------------------------------------------------------------------
// MSB-first bit packer assertion macros
// Assertion helpers shared by the packer RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

`ifndef SYNTH
`define MFBP_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MFBP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFBP_ASSERT_SAME(name, ante, cons, msg)
`define MFBP_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: sv/mfbp_pkg.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Request and result types, the internal job format and shared helpers.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    localparam int MAX_WRITE_BITS = 32;
    localparam int WORD_BITS      = 32;
    localparam logic [7:0] CAPACITY_RESET = 8'd64;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_CLEAR = 1'b1
    } mfbp_op_t;

    typedef struct packed
    {
        logic        opcode;
        logic [31:0] value;
        logic [5:0]  bit_count;
    } mfbp_in_t;

    typedef struct packed
    {
        logic        write_enable;
        logic [7:0]  byte_address;
        logic [7:0]  byte_value;
        logic        accepted;
        logic [10:0] bits_written;
        logic        last;
    } mfbp_out_t;

    // One classified request: nbytes of zero means a single status-only result.
    typedef struct packed
    {
        logic        accepted;
        logic [10:0] bits_written;
        logic [7:0]  base_address;
        logic [2:0]  nbytes;
        logic [39:0] window;
    } mfbp_job_t;

    // Byte idx of the window, counted from the most significant byte.
    function automatic logic [7:0] window_byte(input logic [39:0] window,
                                               input logic [2:0]  idx);
        logic [7:0] result;
        case (idx)
            3'd0:    result = window[39:32];
            3'd1:    result = window[31:24];
            3'd2:    result = window[23:16];
            3'd3:    result = window[15:8];
            3'd4:    result = window[7:0];
            default: result = 8'd0;
        endcase
        return result;
    endfunction

endpackage

FILE: sv/mfbp_front.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer front end
// Classifies each request, updates the bit position and builds its byte window.
// ----------------------------------------------------------------------------
module mfbp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    input  logic              req_accept,
    input  mfbp_pkg::mfbp_in_t req,
    output mfbp_pkg::mfbp_job_t job
);
    import mfbp_pkg::*;

    logic [7:0]  capacity_reg;
    logic [10:0] position_reg;
    logic [10:0] position_next;
    logic [7:0]  partial_reg;
    logic [7:0]  partial_next;

    logic [2:0]  offset;
    logic [7:0]  carried;
    logic [31:0] aligned;
    logic [39:0] window;
    logic [5:0]  span;
    logic [5:0]  span_round;
    logic [2:0]  nbytes;
    logic [10:0] cap_bits;
    logic [10:0] remaining;
    logic        reject;
    logic [10:0] end_position;

    always_comb
    begin
        offset  = position_reg[2:0];
        // A byte whose first bit is about to be written starts cleared.
        carried = (offset == 3'd0) ? 8'd0 : partial_reg;
        aligned = req.value << (6'(WORD_BITS) - req.bit_count);
        window  = {carried, 32'd0} | ({aligned, 8'd0} >> offset);

        span       = {3'd0, offset} + req.bit_count;
        span_round = span + 6'd7;
        nbytes     = span_round[5:3];

        cap_bits  = {capacity_reg, 3'd0};
        remaining = (cap_bits > position_reg) ? cap_bits - position_reg : 11'd0;
        reject    = (req.bit_count > 6'(MAX_WRITE_BITS)) ||
                    (req.bit_count > 6'(WORD_BITS)) ||
                    ({5'd0, req.bit_count} > remaining);

        end_position = position_reg + {5'd0, req.bit_count};

        position_next = position_reg;
        partial_next  = partial_reg;

        job.accepted     = 1'b1;
        job.bits_written = position_reg;
        job.base_address = position_reg[10:3];
        job.nbytes       = 3'd0;
        job.window       = window;

        if (req.opcode == OP_CLEAR)
        begin
            position_next    = 11'd0;
            partial_next     = 8'd0;
            job.bits_written = 11'd0;
        end
        else if (reject)
        begin
            job.accepted = 1'b0;
        end
        else if (req.bit_count != 6'd0)
        begin
            position_next    = end_position;
            partial_next     = window_byte(window, nbytes - 3'd1);
            job.bits_written = end_position;
            job.nbytes       = nbytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
            position_reg <= 11'd0;
            partial_reg  <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (req_accept)
            begin
                position_reg <= position_next;
                partial_reg  <= partial_next;
            end
        end
    end

endmodule

FILE: sv/mfbp_queue.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer job queue
// Small FIFO of classified jobs between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module mfbp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mfbp_pkg::mfbp_job_t  push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output mfbp_pkg::mfbp_job_t  head
);
    import mfbp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mfbp_job_t        entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/mfbp_back.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer byte emitter
// Expands each job into its byte-write results, or its single status result,
// one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module mfbp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  mfbp_pkg::mfbp_job_t job,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output mfbp_pkg::mfbp_out_t out_data
);
    import mfbp_pkg::*;

    logic [2:0] index_reg;
    logic       out_valid_reg;
    mfbp_out_t  out_data_reg;
    mfbp_out_t  result;
    logic       load;

    always_comb
    begin
        result.write_enable = (job.nbytes != 3'd0);
        result.byte_address = result.write_enable ? job.base_address + {5'd0, index_reg} : 8'd0;
        result.byte_value   = result.write_enable ? window_byte(job.window, index_reg) : 8'd0;
        result.accepted     = job.accepted;
        result.bits_written = job.bits_written;
        result.last         = !result.write_enable || (index_reg == job.nbytes - 3'd1);

        load    = job_valid && (!out_valid_reg || !out_stall);
        job_pop = load && result.last;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                index_reg     <= result.last ? 3'd0 : index_reg + 3'd1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// MSB-first bit packer
// Appends 0 to 32 bit values, most significant bit first, to a byte buffer.
// Input channel (in_valid/in_stall/in_data) takes one request per cycle while
// in_stall is low; a request writes bits or clears the position. Output channel
// (out_valid/out_stall/out_data) gives one byte-write result per touched byte,
// or a single status result, with last set on the final one. Config channel
// (cfg_valid/cfg_ready/cfg_data) sets the buffer capacity; it is always ready.
// With the queue empty, the first result of a request passes through the job
// queue and the output register before it is presented. The byte emitter
// produces one result per cycle while out_stall is low, so a request gives 1 to
// 5 results; the front end takes a request every cycle while the job queue has
// room.
// Reset clears the bit position and partial byte and sets capacity to 64.
// When the receiver stalls, the output holds, the queue fills, and then
// in_stall rises.
// ----------------------------------------------------------------------------
`include "msb_first_bit_packer_defines.svh"

module msb_first_bit_packer
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mfbp_pkg::mfbp_in_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mfbp_pkg::mfbp_out_t  out_data
);
    import mfbp_pkg::*;

    mfbp_job_t new_job;
    mfbp_job_t head_job;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_pop;
    logic      req_accept;

    assign cfg_ready  = 1'b1;
    assign in_stall   = queue_full;
    assign req_accept = in_valid && !queue_full;

    mfbp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .req_accept (req_accept),
        .req        (in_data),
        .job        (new_job)
    );

    mfbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_accept),
        .push_data (new_job),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_job)
    );

    mfbp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (head_job),
        .job_pop   (queue_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A multi-byte request delivers its bytes without gaps.
    `MFBP_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !out_data.last, out_valid, "byte burst broken before last result")
    `MFBP_ASSERT_SAME(a_status_single, out_valid && !out_data.write_enable, out_data.last, "status-only result not marked last")
    `MFBP_ASSERT_SAME(a_reject_no_write, out_valid && !out_data.accepted, !out_data.write_enable, "rejected request wrote a byte")

endmodule
